>>> rtl/pfc_pkg.sv
// ============================================================================
// pfc_pkg
// Shared constants, types and cell arithmetic for the Playfair digraph cipher.
// ============================================================================
package pfc_pkg;

    localparam int LTR_W       = 5;    // letter index width
    localparam int CELL_W      = 5;    // square cell index width
    localparam int TDATA_W     = 8;    // stream data width
    localparam int MODE_W      = 3;
    localparam int NUM_LETTERS = 26;
    localparam int NUM_CELLS   = 25;
    localparam int SIDE        = 5;

    localparam logic [LTR_W-1:0] LTR_I = LTR_W'(8);
    localparam logic [LTR_W-1:0] LTR_J = LTR_W'(9);
    localparam logic [LTR_W-1:0] LTR_X = LTR_W'(23);

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 3'd0,
        MODE_KEY    = 3'd1,
        MODE_FINISH = 3'd2,
        MODE_TEXT   = 3'd3,
        MODE_END    = 3'd4
    } mode_t;

    // Two cipher letters of one digraph, first then second.
    typedef struct packed {
        logic [LTR_W-1:0] first;
        logic [LTR_W-1:0] second;
    } pfc_pair_t;

    // I and J share one cell: J maps onto I's entry.
    function automatic logic [LTR_W-1:0] letter_slot(input logic [LTR_W-1:0] ltr);
        return (ltr == LTR_J) ? LTR_I : ltr;
    endfunction

    // Row of a cell index 0..24 (cell / 5).
    function automatic logic [2:0] cell_row(input logic [CELL_W-1:0] c);
        logic [2:0] r;
        if (c >= CELL_W'(4 * SIDE))
            r = 3'd4;
        else if (c >= CELL_W'(3 * SIDE))
            r = 3'd3;
        else if (c >= CELL_W'(2 * SIDE))
            r = 3'd2;
        else if (c >= CELL_W'(SIDE))
            r = 3'd1;
        else
            r = 3'd0;
        return r;
    endfunction

    // Cell index from row and column (row * 5 + col).
    function automatic logic [CELL_W-1:0] cell_at(input logic [2:0] r, input logic [2:0] k);
        return CELL_W'({r, 2'b00}) + CELL_W'(r) + CELL_W'(k);
    endfunction

    // Column of a cell index 0..24 (cell % 5).
    function automatic logic [2:0] cell_col(input logic [CELL_W-1:0] c);
        logic [CELL_W-1:0] base;
        base = cell_at(cell_row(c), 3'd0);
        return 3'(c - base);
    endfunction

    // Step one place along a row or column, wrapping at the edge.
    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

endpackage

>>> rtl/pfc_ram.sv
// ============================================================================
// pfc_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ============================================================================
module pfc_ram #(
    parameter int DEPTH = 26,
    parameter int WIDTH = 5
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

>>> rtl/pfc_out_buf.sv
// ============================================================================
// pfc_out_buf
// Two-letter output buffer: present the first letter, then the second.
// ============================================================================
module pfc_out_buf
    import pfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  pfc_pair_t          pair,
    output logic               empty,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tlast
);

    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic [LTR_W-1:0] first_reg;
    logic [LTR_W-1:0] second_reg;
    logic [LTR_W-1:0] shown;

    assign empty         = (count_reg == 2'd0);
    assign m_axis_tvalid = !empty;
    assign m_axis_tlast  = (count_reg == 2'd1);
    assign shown         = (count_reg == 2'd2) ? first_reg : second_reg;
    assign m_axis_tdata  = {{(TDATA_W - LTR_W){1'b0}}, shown};

    always_comb
    begin
        count_next = count_reg;
        if (load)
            count_next = 2'd2;
        else if (m_axis_tvalid && m_axis_tready)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            first_reg  <= pair.first;
            second_reg <= pair.second;
        end
    end

endmodule

>>> rtl/playfair_digraph_cipher.sv
// ============================================================================
// playfair_digraph_cipher
// Playfair digraph encryption with a key square built on line.
// Flow: the transaction that completes a pair starts a letter RAM read, then a
//   square RAM read, then a buffer load once the buffer is empty; the second
//   cipher letter follows once the first is taken. No input is taken until idle.
// Throughput: one input transaction per cycle for key, clear and held letters
//   while the block is idle; the finish pass fills one letter of the alphabet per cycle.
// Reset: asynchronous, active low; empties the square, drops any held letter.
// ============================================================================
module playfair_digraph_cipher
    import pfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [4:0] letter, [7:5] unused
    input  logic [MODE_W-1:0]  s_axis_tuser,   // [2:0] mode
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [4:0] cipher_letter, [7:5] zero
    output logic               m_axis_tlast    // last_of_pair
);

    // IDLE takes transactions; FINISH walks the alphabet filling the square;
    // CELL has the letter-to-cell reads back; SQUARE has the cipher letters.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FINISH,
        ST_CELL,
        ST_SQUARE
    } state_t;

    state_t                  state_reg, state_next;
    logic [NUM_LETTERS-1:0]  placed_reg, placed_next;   // letter has a cell
    logic [CELL_W-1:0]       filled_reg, filled_next;
    logic                    ready_reg, ready_next;     // square complete
    logic [LTR_W-1:0]        held_letter_reg, held_letter_next;
    logic                    held_valid_reg, held_valid_next;
    logic [LTR_W-1:0]        walk_reg, walk_next;       // finish-pass letter

    logic                    accept;
    mode_t                   mode;
    logic [LTR_W-1:0]        ltr;
    logic                    ltr_ok;
    logic [LTR_W-1:0]        key_slot;
    logic [LTR_W-1:0]        pair_b;

    // Shared write port: a letter goes into the next free cell.
    logic                    wr_en;
    logic [LTR_W-1:0]        wr_letter;

    logic                    cell_rd_en;
    logic [CELL_W-1:0]       cell_a, cell_b;
    logic                    sq_rd_en;
    logic [CELL_W-1:0]       out_cell_a, out_cell_b;
    logic [LTR_W-1:0]        sq_a, sq_b;

    logic [2:0]              ra, ka, rb, kb;
    logic                    buf_empty;
    logic                    load;
    pfc_pair_t               pair;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign mode          = mode_t'(s_axis_tuser);
    assign ltr           = s_axis_tdata[LTR_W-1:0];
    assign ltr_ok        = (ltr < LTR_W'(NUM_LETTERS));
    assign key_slot      = letter_slot(ltr);

    // Second letter of the pair: X pads an end of message, and X replaces
    // a letter that repeats the held one.
    assign pair_b = (mode == MODE_END || ltr == held_letter_reg) ? LTR_X : ltr;

    // Rectangle geometry from the two cells read back.
    assign ra = cell_row(cell_a);
    assign ka = cell_col(cell_a);
    assign rb = cell_row(cell_b);
    assign kb = cell_col(cell_b);

    always_comb
    begin
        if (ka == kb)
        begin
            // same column: shift down
            out_cell_a = cell_at(wrap_inc(ra), ka);
            out_cell_b = cell_at(wrap_inc(rb), ka);
        end
        else if (ra == rb)
        begin
            // same row: shift right
            out_cell_a = cell_at(ra, wrap_inc(ka));
            out_cell_b = cell_at(ra, wrap_inc(kb));
        end
        else
        begin
            // rectangle: swap columns
            out_cell_a = cell_at(ra, kb);
            out_cell_b = cell_at(rb, ka);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        placed_next      = placed_reg;
        filled_next      = filled_reg;
        ready_next       = ready_reg;
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        walk_next        = walk_reg;
        wr_en            = 1'b0;
        wr_letter        = key_slot;
        cell_rd_en       = 1'b0;
        sq_rd_en         = 1'b0;
        load             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_CLEAR:
                        begin
                            placed_next      = '0;
                            filled_next      = '0;
                            ready_next       = 1'b0;
                            held_letter_next = '0;
                            held_valid_next  = 1'b0;
                        end
                        MODE_KEY:
                        begin
                            // place a new key letter; repeats are dropped
                            if (!ready_reg && ltr_ok && !placed_reg[key_slot]
                                && filled_reg < CELL_W'(NUM_CELLS))
                            begin
                                wr_en                 = 1'b1;
                                placed_next[key_slot] = 1'b1;
                                filled_next           = filled_reg + CELL_W'(1);
                            end
                        end
                        MODE_FINISH:
                        begin
                            if (!ready_reg)
                            begin
                                walk_next  = '0;
                                state_next = ST_FINISH;
                            end
                        end
                        MODE_TEXT:
                        begin
                            if (ready_reg && ltr_ok)
                            begin
                                if (!held_valid_reg)
                                begin
                                    held_letter_next = ltr;
                                    held_valid_next  = 1'b1;
                                end
                                else
                                begin
                                    held_valid_next = 1'b0;
                                    cell_rd_en      = 1'b1;
                                    state_next      = ST_CELL;
                                end
                            end
                        end
                        MODE_END:
                        begin
                            if (ready_reg && held_valid_reg)
                            begin
                                held_valid_next = 1'b0;
                                cell_rd_en      = 1'b1;
                                state_next      = ST_CELL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FINISH:
            begin
                // fill the remaining cells alphabetically, skipping J
                wr_letter = walk_reg;
                if (walk_reg != LTR_J && !placed_reg[walk_reg]
                    && filled_reg < CELL_W'(NUM_CELLS))
                begin
                    wr_en                 = 1'b1;
                    placed_next[walk_reg] = 1'b1;
                    filled_next           = filled_reg + CELL_W'(1);
                end
                if (walk_reg == LTR_W'(NUM_LETTERS - 1))
                begin
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    walk_next = walk_reg + LTR_W'(1);
                end
            end
            ST_CELL:
            begin
                sq_rd_en   = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                // hold the square read data until the buffer drains
                if (buf_empty)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            placed_reg      <= '0;
            filled_reg      <= '0;
            ready_reg       <= 1'b0;
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
            walk_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            placed_reg      <= placed_next;
            filled_reg      <= filled_next;
            ready_reg       <= ready_next;
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
            walk_reg        <= walk_next;
        end
    end

    // Letter to cell. J is never written; it reads through I's entry.
    // Reads and writes never overlap: writes happen only while the square
    // is being built, reads only once it is complete.
    pfc_ram #(
        .DEPTH (NUM_LETTERS),
        .WIDTH (CELL_W)
    ) u_cell_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_letter),
        .wr_data   (filled_reg),
        .rd_en     (cell_rd_en),
        .rd_addr_a (letter_slot(held_letter_reg)),
        .rd_addr_b (letter_slot(pair_b)),
        .rd_data_a (cell_a),
        .rd_data_b (cell_b)
    );

    // Cell to letter.
    pfc_ram #(
        .DEPTH (NUM_CELLS),
        .WIDTH (LTR_W)
    ) u_square_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (filled_reg),
        .wr_data   (wr_letter),
        .rd_en     (sq_rd_en),
        .rd_addr_a (out_cell_a),
        .rd_addr_b (out_cell_b),
        .rd_data_a (sq_a),
        .rd_data_b (sq_b)
    );

    assign pair.first  = sq_a;
    assign pair.second = sq_b;

    pfc_out_buf u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .pair          (pair),
        .empty         (buf_empty),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> rtl/pfc_checker.sv
// ============================================================================
// pfc_checker
// Port-level checks on the cipher output stream, bound to the top level.
// ============================================================================
module pfc_checker
    import pfc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [TDATA_W-1:0] s_axis_tdata,
    input logic [MODE_W-1:0]  s_axis_tuser,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast
);

    // A stalled transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // Cipher letters are in range with zero padding.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata[TDATA_W-1:LTR_W] == '0
            && m_axis_tdata[LTR_W-1:0] < LTR_W'(NUM_LETTERS))
        else $error("cipher letter out of range");

    // The second letter of a digraph follows right after the first.
    a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tlast)
        else $error("digraph second letter missing");

    // A completed digraph is never directly followed by another letter.
    a_pair_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("letter emitted without its digraph gap");

    // After a clear, key or out-of-range text transaction the input is ready in the next cycle.
    a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
            && (s_axis_tuser == MODE_CLEAR || s_axis_tuser == MODE_KEY
                || (s_axis_tuser == MODE_TEXT
                    && s_axis_tdata[LTR_W-1:0] >= LTR_W'(NUM_LETTERS)))
            |=> s_axis_tready)
        else $error("input stalled after a single-cycle transaction");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/playfair_digraph_cipher_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// playfair_digraph_cipher_tb
// Self-checking bench for the Playfair digraph cipher. A behavioral copy of
// the key square and pair logic predicts every cipher letter. A checker
// process compares each output transaction with the oldest prediction.
// Stimulus is a short directed sequence, then random key/message sessions
// with random idling on both sides, then a burst with no idling at all.
// ============================================================================
module playfair_digraph_cipher_tb;
    import pfc_pkg::*;

    // Mode codes the block must ignore.
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
    // All-ones letter field, outside A..Z.
    localparam logic [LTR_W-1:0]  LTR_OUT_OF_RANGE = 5'h1F;

    localparam int IDLE_PCT    = 38;
    localparam int STUCK_LIMIT = 1000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 40;   // finish-square pass plus pair latency

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;   // [4:0] letter, [7:5] zero
    logic [MODE_W-1:0]  s_axis_tuser = '0;   // [2:0] mode
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // [4:0] cipher_letter, [7:5] zero
    logic               m_axis_tlast;        // last_of_pair

    playfair_digraph_cipher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predicted key square and pair state
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [LTR_W-1:0] ltr;
        logic             last;
    } cipher_out_t;

    logic [CELL_W-1:0] letter_pos [NUM_LETTERS];  // 0 = not placed, else cell + 1
    logic [LTR_W-1:0]  sq_letter [NUM_CELLS];
    int unsigned       sq_count;
    bit                sq_ready;
    logic [LTR_W-1:0]  held_ltr;
    bit                held_ok;

    cipher_out_t pending_cipher [$];

    int unsigned errors        = 0;
    int unsigned items_sent    = 0;
    int unsigned items_used    = 0;  // transactions that changed state or made output
    int unsigned letters_seen  = 0;
    int unsigned pairs_encrypted = 0;
    int unsigned sessions      = 0;
    bit          tx_idle_en    = 1'b1;
    bit          rx_idle_en    = 1'b1;
    int unsigned stuck_cycles  = 0;

    function automatic void square_clear();
        foreach (letter_pos[i])
            letter_pos[i] = '0;
        foreach (sq_letter[i])
            sq_letter[i] = '0;
        sq_count = 0;
        sq_ready = 1'b0;
        held_ltr = '0;
        held_ok  = 1'b0;
    endfunction

    // Put a letter in the next free cell and record where it went.
    function automatic void square_place(int unsigned slot, logic [LTR_W-1:0] ltr);
        if (sq_count >= NUM_CELLS)
            return;
        sq_letter[sq_count] = ltr;
        sq_count++;
        letter_pos[slot] = CELL_W'(sq_count);
    endfunction

    // Apply the column, row or rectangle rule and queue both cipher letters.
    function automatic void encrypt_pair(logic [LTR_W-1:0] a, logic [LTR_W-1:0] b);
        int unsigned ca, cb, ra, ka, rb, kb, oa, ob;
        ca = int'(letter_pos[a]) - 1;
        cb = int'(letter_pos[b]) - 1;
        ra = ca / SIDE;
        ka = ca % SIDE;
        rb = cb / SIDE;
        kb = cb % SIDE;
        if (ka == kb)
        begin
            oa = ((ra + 1) % SIDE) * SIDE + ka;
            ob = ((rb + 1) % SIDE) * SIDE + ka;
        end
        else if (ra == rb)
        begin
            oa = ra * SIDE + (ka + 1) % SIDE;
            ob = ra * SIDE + (kb + 1) % SIDE;
        end
        else
        begin
            oa = ra * SIDE + kb;
            ob = rb * SIDE + ka;
        end
        pending_cipher.push_back('{ltr: sq_letter[oa % NUM_CELLS], last: 1'b0});
        pending_cipher.push_back('{ltr: sq_letter[ob % NUM_CELLS], last: 1'b1});
        pairs_encrypted++;
    endfunction

    // Advance the predicted state by one accepted transaction.
    // Returns 1 when the transaction had any effect.
    function automatic bit encrypt_step(logic [MODE_W-1:0] md, logic [LTR_W-1:0] ltr);
        bit ltr_ok;
        ltr_ok = (ltr < NUM_LETTERS);
        case (md)
            MODE_CLEAR:
            begin
                square_clear();
                return 1'b1;
            end
            MODE_KEY:
            begin
                if (sq_ready || !ltr_ok || letter_pos[ltr] != '0)
                    return 1'b0;
                // I and J share one cell; either one places I
                if (ltr == LTR_I || ltr == LTR_J)
                begin
                    square_place(LTR_I, LTR_I);
                    letter_pos[LTR_J] = letter_pos[LTR_I];
                end
                else
                    square_place(ltr, ltr);
                return 1'b1;
            end
            MODE_FINISH:
            begin
                if (sq_ready)
                    return 1'b0;
                for (int k = 0; k < NUM_LETTERS; k++)
                    if (k != LTR_J && letter_pos[k] == '0)
                        square_place(k, LTR_W'(k));
                letter_pos[LTR_J] = letter_pos[LTR_I];
                sq_ready = 1'b1;
                return 1'b1;
            end
            MODE_TEXT:
            begin
                if (!sq_ready || !ltr_ok)
                    return 1'b0;
                if (!held_ok)
                begin
                    held_ltr = ltr;
                    held_ok  = 1'b1;
                    return 1'b1;
                end
                held_ok = 1'b0;
                // a doubled letter is replaced, not split
                encrypt_pair(held_ltr, (ltr == held_ltr) ? LTR_X : ltr);
                return 1'b1;
            end
            MODE_END:
            begin
                if (!sq_ready || !held_ok)
                    return 1'b0;
                held_ok = 1'b0;
                encrypt_pair(held_ltr, LTR_X);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Send one transaction; hold it until the block takes it.
    task automatic send_item(input logic [MODE_W-1:0] md, input logic [LTR_W-1:0] ltr);
        while (tx_idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= md;
        s_axis_tdata  <= TDATA_W'(ltr);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (encrypt_step(md, ltr))
            items_used++;
    endtask

    // Random backpressure, or none while rx idling is off.
    always @(posedge clk)
    begin
        m_axis_tready <= !rx_idle_en || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare every output transaction with the oldest prediction.
    always @(posedge clk)
    begin
        cipher_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            letters_seen++;
            if (pending_cipher.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected cipher letter: expected none, actual %0d last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = pending_cipher.pop_front();
                if (m_axis_tdata != TDATA_W'(want.ltr))
                begin
                    errors++;
                    $display("%0t ns: cipher_letter mismatch: expected %0d, actual %0d",
                             $time, want.ltr, m_axis_tdata);
                end
                if (m_axis_tlast != want.last)
                begin
                    errors++;
                    $display("%0t ns: last_of_pair mismatch: expected %0b, actual %0b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    // Abort when neither side moves for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles, %0d cipher letters outstanding",
                     $time, STUCK_LIMIT, pending_cipher.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked corner cases. Square after key J, Z:
    //   I Z A B C / D E F G H / K L M N O / P Q R S T / U V W X Y
    task automatic test_directed();
        send_item(MODE_TEXT, 5'd0);                 // drop: square not ready
        send_item(MODE_END, 5'd0);                  // drop: square not ready
        send_item(MODE_KEY, LTR_J);                 // J places I
        send_item(MODE_KEY, LTR_I);                 // already placed
        send_item(MODE_KEY, 5'd25);                 // Z
        send_item(MODE_KEY, 5'd25);                 // repeat key letter
        send_item(MODE_KEY, LTR_OUT_OF_RANGE);      // letter above Z
        send_item(MODE_UNUSED_HI, LTR_OUT_OF_RANGE);
        send_item(MODE_UNUSED_LO, 5'd3);
        send_item(MODE_FINISH, 5'd0);
        send_item(MODE_KEY, 5'd0);                  // key after square is ready
        send_item(MODE_FINISH, 5'd0);               // second finish is a no-op
        send_item(MODE_TEXT, 5'd0);                 // A A: doubled letter
        send_item(MODE_TEXT, 5'd0);
        send_item(MODE_TEXT, LTR_X);                // X X: doubled X
        send_item(MODE_TEXT, LTR_X);
        send_item(MODE_TEXT, LTR_I);                // I J: same cell, column rule
        send_item(MODE_TEXT, LTR_J);
        send_item(MODE_TEXT, 5'd1);                 // B, skip bad letter, then C: row
        send_item(MODE_TEXT, 5'd30);
        send_item(MODE_TEXT, 5'd2);
        send_item(MODE_TEXT, 5'd4);                 // lone E padded with X
        send_item(MODE_END, 5'd0);
        send_item(MODE_END, 5'd0);                  // nothing held
        send_item(MODE_TEXT, 5'd5);                 // held letter dropped by clear
        send_item(MODE_CLEAR, 5'd0);
    endtask

    // Garbage transaction: random non-clear mode and random letter field, rarely a clear.
    task automatic send_noise();
        logic [MODE_W-1:0] md;
        md = ($urandom_range(15) == 0) ? MODE_CLEAR : MODE_W'($urandom_range(1, 7));
        send_item(md, LTR_W'($urandom_range(0, 31)));
    endtask

    // Full sessions: clear, key word, finish, message, optional end.
    task automatic run_sessions(input int unsigned n_items);
        int unsigned      stop_at, key_len, msg_len;
        logic [LTR_W-1:0] prev, ltr;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            sessions++;
            send_item(MODE_CLEAR, LTR_W'($urandom_range(0, 31)));
            key_len = ($urandom_range(7) == 0) ? 30 : $urandom_range(0, 12);
            for (int i = 0; i < key_len; i++)
            begin
                if ($urandom_range(15) == 0)
                    send_noise();
                send_item(MODE_KEY, LTR_W'($urandom_range(0, NUM_LETTERS - 1)));
            end
            send_item(MODE_FINISH, LTR_W'($urandom_range(0, 31)));
            msg_len = $urandom_range(0, 40);
            prev = '0;
            for (int i = 0; i < msg_len; i++)
            begin
                if ($urandom_range(19) == 0)
                    send_noise();
                case ($urandom_range(9))
                    0, 1:    ltr = prev;  // provoke doubled pairs
                    2:       ltr = ($urandom_range(2) == 0) ? LTR_I :
                                   ($urandom_range(1) == 0) ? LTR_J : LTR_X;
                    default: ltr = LTR_W'($urandom_range(0, NUM_LETTERS - 1));
                endcase
                send_item(MODE_TEXT, ltr);
                prev = ltr;
            end
            if ($urandom_range(7) != 0)
                send_item(MODE_END, LTR_W'($urandom_range(0, 31)));
        end
    endtask

    task automatic test_random_traffic();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_sessions(1500);
    endtask

    // Long stretch with both sides always ready.
    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_sessions(430);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial
    begin
        square_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic();
        test_back_to_back();

        s_axis_tvalid <= 1'b0;
        while (pending_cipher.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_cipher.size() != 0)
        begin
            errors++;
            $display("%0t ns: %0d predicted cipher letters never arrived",
                     $time, pending_cipher.size());
        end

        $display("Covered %0d sessions: %0d input transactions (%0d effective), %0d pairs",
                 sessions, items_sent, items_used, pairs_encrypted);
        $display("Checked %0d cipher letters, %0d errors", letters_seen, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pfc_pkg.sv
rtl/pfc_ram.sv
rtl/pfc_out_buf.sv
rtl/playfair_digraph_cipher.sv
rtl/pfc_checker.sv
tb/playfair_digraph_cipher_tb.sv
